@@ hdl/wma_pkg.sv @@
// Shared types and constants of the waveform moment accumulator.
package wma_pkg;

    localparam int ACTION_W = 1;
    localparam int GAIN_W   = 1;
    localparam int CHAN_W   = 4;
    localparam int SIDX_W   = 5;
    localparam int VALUE_W  = 16;
    localparam int KIND_W   = 2;
    localparam int PIDX_W   = 9;
    localparam int RESULT_W = 64;
    localparam int COUNT_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int SIU_W      = 6;
    localparam int NACT_W     = 8;

    localparam logic [ACTION_W-1:0] ACT_ACCUM = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_COUNT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUM   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SQ    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PAIR  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COV_ENABLE     = 1'b1;

    localparam logic [SIU_W-1:0] SIU_RESET = 6'd32;
    localparam logic             COV_RESET = 1'b1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [GAIN_W-1:0]   gain;
        logic [CHAN_W-1:0]   channel;
        logic [SIDX_W-1:0]   sample_index;
        logic [VALUE_W-1:0]  sample_value;
        logic [KIND_W-1:0]   stat_kind;
        logic [PIDX_W-1:0]   pair_index;
    } t_item;

    typedef struct packed {
        logic clear;
        logic latch;
        logic issue;
        logic commit;
        logic load_out;
        logic pair_issue;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_read;
        logic acc_ok;
        logic pair_need;
        logic pair_last;
        logic out_free;
    } t_sts;

endpackage

@@ hdl/wma_req_if.sv @@
// Request channel: accumulate and read transactions.
interface wma_req_if;
    logic                         valid;
    logic                         ready;
    logic [wma_pkg::ACTION_W-1:0] action;
    logic [wma_pkg::GAIN_W-1:0]   gain;
    logic [wma_pkg::CHAN_W-1:0]   channel;
    logic [wma_pkg::SIDX_W-1:0]   sample_index;
    logic [wma_pkg::VALUE_W-1:0]  sample_value;
    logic [wma_pkg::KIND_W-1:0]   stat_kind;
    logic [wma_pkg::PIDX_W-1:0]   pair_index;

    modport source (output valid, action, gain, channel, sample_index, sample_value,
                    stat_kind, pair_index, input ready);
    modport sink (input valid, action, gain, channel, sample_index, sample_value,
                  stat_kind, pair_index, output ready);
endinterface

@@ hdl/wma_rsp_if.sv @@
// Response channel: one statistic per read transaction.
interface wma_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [wma_pkg::RESULT_W-1:0] read_value;

    modport source (output valid, read_value, input ready);
    modport sink (input valid, read_value, output ready);
endinterface

@@ hdl/wma_ctrl.sv @@
// Sequencing state machine of the waveform moment accumulator.
module wma_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  wma_pkg::t_sts i_sts,
    output wma_pkg::t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_ISSUE = 6'b000100,
        S_DATA  = 6'b001000,
        S_PAIR  = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_state     = S_DATA;
            end
            S_DATA: begin
                if (i_sts.is_read) begin
                    if (i_sts.out_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.acc_ok) begin
                    o_cmd.commit = 1'b1;
                    n_state      = i_sts.pair_need ? S_PAIR : S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAIR: begin
                o_cmd.pair_issue = 1'b1;
                if (i_sts.pair_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

@@ hdl/wma_datapath.sv @@
// Statistic memories, pair product pipeline and result register.
module wma_datapath #(
    parameter int NUM_CHANNELS = 16,
    parameter int MAX_SAMPLES  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wma_pkg::t_item                    i_item,
    input  logic                              i_cfg_we,
    input  logic [wma_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wma_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wma_pkg::t_cmd                     i_cmd,
    output wma_pkg::t_sts                     o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [wma_pkg::RESULT_W-1:0]      o_read_value
);

    localparam int NUM_PAIRS = MAX_SAMPLES * (MAX_SAMPLES - 1) / 2;
    localparam int CNT_DEPTH = 2 * NUM_CHANNELS;
    localparam int SUM_DEPTH = CNT_DEPTH * MAX_SAMPLES;
    localparam int PR_DEPTH  = CNT_DEPTH * NUM_PAIRS;
    localparam int CLR_DEPTH = (SUM_DEPTH > PR_DEPTH) ? SUM_DEPTH : PR_DEPTH;
    localparam int WW  = $clog2(CNT_DEPTH);
    localparam int SAW = $clog2(SUM_DEPTH);
    localparam int PAW = $clog2(PR_DEPTH);
    localparam int CLW = $clog2(CLR_DEPTH);
    localparam int CWW = $clog2(MAX_SAMPLES);
    localparam int NW  = wma_pkg::NACT_W;
    localparam int VW  = wma_pkg::VALUE_W;
    localparam int RW  = wma_pkg::RESULT_W;
    localparam int CW  = wma_pkg::COUNT_W;
    localparam int SW  = wma_pkg::SIDX_W;

    // Configuration registers.
    logic [wma_pkg::SIU_W-1:0] r_siu;
    logic                      r_cov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_siu <= wma_pkg::SIU_RESET;
            r_cov <= wma_pkg::COV_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wma_pkg::CFG_SAMPLES_IN_USE: r_siu <= i_cfg_data[wma_pkg::SIU_W-1:0];
                wma_pkg::CFG_COV_ENABLE:     r_cov <= i_cfg_data[0];
                default:                     r_siu <= r_siu;
            endcase
        end
    end

    // Active sample count, limited to the storage.
    logic [NW-1:0] n_act;
    assign n_act = (NW'(r_siu) > NW'(MAX_SAMPLES)) ? NW'(MAX_SAMPLES) : NW'(r_siu);

    // Item decode.
    logic           chan_ok;
    logic [WW-1:0]  wave;
    logic           rd_ok;
    assign chan_ok = int'(i_item.channel) < NUM_CHANNELS;
    assign wave    = i_item.gain ? (WW'(NUM_CHANNELS) + WW'(i_item.channel))
                                 : WW'(i_item.channel);
    always_comb begin
        unique case (i_item.stat_kind)
            wma_pkg::KIND_COUNT: rd_ok = chan_ok;
            wma_pkg::KIND_SUM,
            wma_pkg::KIND_SQ:    rd_ok = chan_ok && (int'(i_item.sample_index) < MAX_SAMPLES);
            wma_pkg::KIND_PAIR:  rd_ok = chan_ok && (int'(i_item.pair_index) < NUM_PAIRS);
            default:             rd_ok = 1'b0;
        endcase
    end

    // Latched transaction.
    logic                       r_is_read;
    logic                       r_acc_ok;
    logic                       r_rd_ok;
    logic [wma_pkg::KIND_W-1:0] r_kind;
    logic [SW-1:0]              r_sidx;
    logic [VW-1:0]              r_v;
    logic [wma_pkg::PIDX_W-1:0] r_pidx;
    logic [WW-1:0]              r_wave;
    logic [SAW-1:0]             r_saddr;
    logic [PAW-1:0]             r_pbase;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_is_read <= i_item.action == wma_pkg::ACT_READ;
            r_acc_ok  <= chan_ok && (NW'(i_item.sample_index) < n_act);
            r_rd_ok   <= rd_ok;
            r_kind    <= i_item.stat_kind;
            r_sidx    <= i_item.sample_index;
            r_v       <= i_item.sample_value;
            r_pidx    <= i_item.pair_index;
            r_wave    <= wave;
            r_saddr   <= SAW'(wave) * SAW'(MAX_SAMPLES) + SAW'(i_item.sample_index);
            r_pbase   <= PAW'(wave) * PAW'(NUM_PAIRS);
        end
    end

    // Pair walk: index i, triangular slot and slot increment.
    logic [SW-1:0]  r_i;
    logic [PAW-1:0] r_slot;
    logic [NW-1:0]  r_step;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_i    <= '0;
            r_slot <= PAW'(SW'(i_item.sample_index - SW'(1)));
            r_step <= n_act - NW'(2);
        end else if (i_cmd.pair_issue) begin
            r_i    <= r_i + SW'(1);
            r_slot <= r_slot + PAW'(r_step);
            r_step <= r_step - NW'(1);
        end
    end

    // Clearing sweep after reset.
    logic [CLW-1:0] r_clr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + CLW'(1);
        end
    end

    // Pair write-back pipeline flag.
    logic           r_pv;
    logic [PAW-1:0] r_pwa;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.pair_issue;
        end
    end

    logic [PAW-1:0] pair_ra;
    assign pair_ra = r_pbase + (r_is_read ? PAW'(r_pidx) : r_slot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_issue) begin
            r_pwa <= pair_ra;
        end
    end

    // Current waveform buffer.
    logic [VW-1:0] r_cw_mem [MAX_SAMPLES];
    logic [VW-1:0] r_cw_q;
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_cw_mem[CWW'(r_sidx)] <= r_v;
        end
        if (i_cmd.pair_issue) begin
            r_cw_q <= r_cw_mem[CWW'(r_i)];
        end
    end

    // Waveform counts.
    logic [CW-1:0] r_cnt_mem [CNT_DEPTH];
    logic [CW-1:0] r_cnt_q;
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            if (int'(r_clr) < CNT_DEPTH) begin
                r_cnt_mem[r_clr[WW-1:0]] <= '0;
            end
        end else if (i_cmd.commit && (r_sidx == '0)) begin
            r_cnt_mem[r_wave] <= r_cnt_q + CW'(1);
        end
        if (i_cmd.issue) begin
            r_cnt_q <= r_cnt_mem[r_wave];
        end
    end

    // Sums.
    logic [RW-1:0] r_sum_mem [SUM_DEPTH];
    logic [RW-1:0] r_sum_q;
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            if (int'(r_clr) < SUM_DEPTH) begin
                r_sum_mem[r_clr[SAW-1:0]] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_sum_mem[r_saddr] <= r_sum_q + RW'(r_v);
        end
        if (i_cmd.issue) begin
            r_sum_q <= r_sum_mem[r_saddr];
        end
    end

    // Sums of squares.
    logic [RW-1:0] r_sq_mem [SUM_DEPTH];
    logic [RW-1:0] r_sq_q;
    logic [2*VW-1:0] sq;
    assign sq = (2*VW)'(r_v) * (2*VW)'(r_v);
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            if (int'(r_clr) < SUM_DEPTH) begin
                r_sq_mem[r_clr[SAW-1:0]] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_sq_mem[r_saddr] <= r_sq_q + RW'(sq);
        end
        if (i_cmd.issue) begin
            r_sq_q <= r_sq_mem[r_saddr];
        end
    end

    // Pair product sums.
    logic [RW-1:0]   r_pr_mem [PR_DEPTH];
    logic [RW-1:0]   r_pair_q;
    logic [2*VW-1:0] prod;
    assign prod = (2*VW)'(r_cw_q) * (2*VW)'(r_v);
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            if (int'(r_clr) < PR_DEPTH) begin
                r_pr_mem[r_clr[PAW-1:0]] <= '0;
            end
        end else if (r_pv) begin
            r_pr_mem[r_pwa] <= r_pair_q + RW'(prod);
        end
        if (i_cmd.issue || i_cmd.pair_issue) begin
            r_pair_q <= r_pr_mem[pair_ra];
        end
    end

    // Result register.
    logic [RW-1:0] rd_sel;
    always_comb begin
        unique case (r_kind)
            wma_pkg::KIND_COUNT: rd_sel = RW'(r_cnt_q);
            wma_pkg::KIND_SUM:   rd_sel = r_sum_q;
            wma_pkg::KIND_SQ:    rd_sel = r_sq_q;
            wma_pkg::KIND_PAIR:  rd_sel = r_pair_q;
            default:             rd_sel = '0;
        endcase
    end

    logic          r_ov;
    logic [RW-1:0] r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= r_rd_ok ? rd_sel : '0;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_read_value = r_out;

    assign o_sts.clr_done  = r_clr == CLW'(CLR_DEPTH - 1);
    assign o_sts.is_read   = r_is_read;
    assign o_sts.acc_ok    = r_acc_ok;
    assign o_sts.pair_need = r_cov && (r_sidx != '0);
    assign o_sts.pair_last = r_i == SW'(r_sidx - SW'(1));
    assign o_sts.out_free  = !r_ov || i_out_ready;

endmodule

@@ hdl/waveform_moment_accumulator_core.sv @@
// Top level of the waveform moment accumulator.
//
// Requests arrive on i_req as transactions. An accumulate transaction adds one
// sample to the sum and sum of squares of its gain, channel and position,
// counts a waveform of its gain and channel at index 0, and, with covariance
// enabled, adds its products with the earlier buffered samples of the waveform
// to the pair sums. A read transaction returns one statistic as a transaction
// on o_rsp; accumulates return nothing. One transaction is handled at a time.
// A read and an accumulate both pass through the issue and data states; when
// pair products are summed, an accumulate then walks its earlier samples in
// the pair state and ends in the drain state, since the pair sum memory does
// one read-modify-write per cycle through a single 16x16 multiplier. The
// result sits in an output register, so a stalled receiver only holds up the
// block when a second read finishes while the first result is unclaimed.
// After reset the block sweeps all statistic memories to zero, one entry per
// cycle, with i_req.ready low; configuration writes are taken at any time.
// Register 0 is samples_in_use and register 1 is covariance_enable; write them
// only while the block is idle.
module waveform_moment_accumulator_core #(
    parameter int NUM_CHANNELS = 16,
    parameter int MAX_SAMPLES  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wma_req_if.sink                        i_req,
    wma_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [wma_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wma_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    wma_pkg::t_cmd  cmd;
    wma_pkg::t_sts  sts;
    wma_pkg::t_item item;

    // Pack the request payload into one bundle for the datapath.
    assign item.action       = i_req.action;
    assign item.gain         = i_req.gain;
    assign item.channel      = i_req.channel;
    assign item.sample_index = i_req.sample_index;
    assign item.sample_value = i_req.sample_value;
    assign item.stat_kind    = i_req.stat_kind;
    assign item.pair_index   = i_req.pair_index;

    wma_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    wma_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_SAMPLES  (MAX_SAMPLES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_read_value (o_rsp.read_value)
    );

    // No request is taken while the memories are being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !i_req.ready)
        else $error("request accepted during clearing sweep");

    // A result is loaded only when the output register can take it.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over an unclaimed result");

    // A loaded result is offered in the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_rsp.valid)
        else $error("loaded result not offered");

    // The pending pair write-back completes before a new request is taken.
    a_pair_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pair_issue |=> !cmd.latch)
        else $error("request taken with a pair write-back pending");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the waveform moment accumulator core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH   = 16;
    localparam int NS    = 32;
    localparam int NPAIR = NS * (NS - 1) / 2;
    localparam int NWAVE = 2 * NCH;
    // The limit allows for the clearing sweep after reset, which runs without an acceptance.
    localparam int IDLE_LIMIT = 60000;
    localparam int SETTLE     = 60;

    localparam int GW  = wma_pkg::GAIN_W;
    localparam int CHW = wma_pkg::CHAN_W;
    localparam int SXW = wma_pkg::SIDX_W;
    localparam int VLW = wma_pkg::VALUE_W;
    localparam int KW  = wma_pkg::KIND_W;
    localparam int PXW = wma_pkg::PIDX_W;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [wma_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [wma_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    wma_req_if req_ch ();
    wma_rsp_if rsp_ch ();

    waveform_moment_accumulator_core #(
        .NUM_CHANNELS(NCH),
        .MAX_SAMPLES (NS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the block's configuration and statistic stores.
    logic [wma_pkg::SIU_W-1:0] shadow_siu = wma_pkg::SIU_RESET;
    logic             shadow_cov = wma_pkg::COV_RESET;
    logic [15:0] wave_buf [NS];
    bit          buf_loaded [NS];
    logic [31:0] wave_counts [NWAVE];
    logic [63:0] sums [NWAVE*NS];
    logic [63:0] squares [NWAVE*NS];
    logic [63:0] pair_sums [NWAVE*NPAIR];

    // Read results that the block still owes us, oldest first.
    logic [63:0] owed_stats [$];

    int  error_count = 0;
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  quiet_sender = 0;
    int  hold_request = 0;
    int  hold_seen = 0;
    int  hold_left = 0;

    initial begin
        for (int k = 0; k < NWAVE; k++) wave_counts[k] = '0;
        for (int k = 0; k < NWAVE*NS; k++) begin
            sums[k] = '0;
            squares[k] = '0;
        end
        for (int k = 0; k < NWAVE*NPAIR; k++) pair_sums[k] = '0;
        for (int k = 0; k < NS; k++) begin
            wave_buf[k] = '0;
            buf_loaded[k] = 0;
        end
    end

    // Applies one accepted transaction to the shadow state and queues any read result.
    function automatic void apply_transaction(wma_pkg::t_item it);
        int n;
        int w;
        int j;
        int slot;
        logic [63:0] v;
        logic [63:0] r;
        w = int'(it.gain) * NCH + int'(it.channel);
        j = int'(it.sample_index);
        if (it.action == wma_pkg::ACT_READ) begin
            r = '0;
            case (it.stat_kind)
                wma_pkg::KIND_COUNT: r = {32'd0, wave_counts[w]};
                wma_pkg::KIND_SUM:   r = sums[w*NS + j];
                wma_pkg::KIND_SQ:    r = squares[w*NS + j];
                wma_pkg::KIND_PAIR:
                    if (int'(it.pair_index) < NPAIR)
                        r = pair_sums[w*NPAIR + int'(it.pair_index)];
                default:    r = '0;
            endcase
            owed_stats.push_back(r);
            return;
        end
        n = (int'(shadow_siu) > NS) ? NS : int'(shadow_siu);
        if (j >= n) return;
        v = {48'd0, it.sample_value};
        if (j == 0) wave_counts[w] += 32'd1;
        sums[w*NS + j] += v;
        squares[w*NS + j] += v * v;
        if (shadow_cov) begin
            for (int i = 0; i < j; i++) begin
                slot = n*(n-1)/2 - (n-i)*(n-i-1)/2 + (j-i-1);
                pair_sums[w*NPAIR + slot] += {48'd0, wave_buf[i]} * v;
            end
        end
        wave_buf[j] = it.sample_value;
        buf_loaded[j] = 1;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        if (quiet_sender) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one transaction, waits for the handshake, then idles for a random gap.
    task automatic send_item(wma_pkg::t_item it);
        int gap;
        req_ch.valid        <= 1'b1;
        req_ch.action       <= it.action;
        req_ch.gain         <= it.gain;
        req_ch.channel      <= it.channel;
        req_ch.sample_index <= it.sample_index;
        req_ch.sample_value <= it.sample_value;
        req_ch.stat_kind    <= it.stat_kind;
        req_ch.pair_index   <= it.pair_index;
        do @(posedge i_clk); while (!req_ch.ready);
        apply_transaction(it);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic accumulate(int g, int ch, int idx, int value);
        wma_pkg::t_item it;
        it = '0;
        it.action = wma_pkg::ACT_ACCUM;
        it.gain = GW'(g);
        it.channel = CHW'(ch);
        it.sample_index = SXW'(idx);
        it.sample_value = VLW'(value);
        it.stat_kind = KW'($urandom_range(0, 3));
        it.pair_index = PXW'($urandom_range(0, 511));
        send_item(it);
    endtask

    task automatic read_stat(int g, int ch, logic [wma_pkg::KIND_W-1:0] kind, int idx, int pidx);
        wma_pkg::t_item it;
        it = '0;
        it.action = wma_pkg::ACT_READ;
        it.gain = GW'(g);
        it.channel = CHW'(ch);
        it.sample_index = SXW'(idx);
        it.stat_kind = kind;
        it.pair_index = PXW'(pidx);
        it.sample_value = VLW'($urandom_range(0, 65535));
        send_item(it);
    endtask

    // Waits until every owed result has come back, then lets a trailing accumulate finish.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (owed_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(logic [wma_pkg::CFG_IDX_W-1:0] idx,
                                  logic [wma_pkg::CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == wma_pkg::CFG_SAMPLES_IN_USE) shadow_siu = data;
        else shadow_cov = data[0];
    endtask

    // Index j is only legal once every earlier buffer position has been filled.
    function automatic int legal_index(int j);
        for (int i = 0; i < j; i++)
            if (!buf_loaded[i]) return 0;
        return j;
    endfunction

    // Extremes of the sample value, every statistic kind, and reads past storage.
    task automatic test_directed();
        accumulate(0, 0, 0, 16'h0000);
        accumulate(0, 0, 1, 16'hFFFF);
        accumulate(0, 0, 2, 16'h0001);
        accumulate(0, 0, 3, 16'h8000);
        accumulate(1, 15, 0, 16'hFFFF);
        accumulate(1, 15, 1, 16'hFFFF);
        read_stat(0, 0, wma_pkg::KIND_COUNT, 0, 0);
        read_stat(0, 0, wma_pkg::KIND_SUM, 1, 0);
        read_stat(0, 0, wma_pkg::KIND_SQ, 1, 0);
        read_stat(1, 15, wma_pkg::KIND_SQ, 1, 0);
        read_stat(0, 0, wma_pkg::KIND_PAIR, 0, 0);
        read_stat(0, 0, wma_pkg::KIND_PAIR, 31, 31);
        read_stat(1, 15, wma_pkg::KIND_PAIR, 0, 0);
        read_stat(0, 0, wma_pkg::KIND_PAIR, 0, NPAIR - 1);
        read_stat(0, 0, wma_pkg::KIND_PAIR, 0, NPAIR);
        read_stat(0, 0, wma_pkg::KIND_PAIR, 0, 511);
        read_stat(1, 15, wma_pkg::KIND_COUNT, 31, 0);
        read_stat(0, 7, wma_pkg::KIND_SUM, 31, 0);
        // A stale waveform: a sample is repeated and the channel changes midway.
        accumulate(0, 0, 2, 16'h1234);
        accumulate(0, 3, 3, 16'hABCD);
        read_stat(0, 3, wma_pkg::KIND_PAIR, 0, 2);
        read_stat(0, 0, wma_pkg::KIND_SQ, 2, 0);
    endtask

    // One well-formed waveform with random content, followed by a few reads of it.
    task automatic random_waveform(int n_active);
        int g;
        int ch;
        int len;
        int last;
        g = $urandom_range(0, 1);
        ch = $urandom_range(0, NCH - 1);
        last = (n_active < 1) ? 1 : n_active;
        len = ($urandom_range(0, 9) == 0) ? last : $urandom_range(1, (last < 8) ? last : 8);
        for (int j = 0; j < len; j++) accumulate(g, ch, legal_index(j), $urandom_range(0, 65535));
        repeat ($urandom_range(1, 3))
            read_stat(g, ch, KW'($urandom_range(0, 3)), $urandom_range(0, len),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                : $urandom_range(0, 2 * len));
    endtask

    // Noise: a lone accumulate at any legal index, or a read of anything at all.
    task automatic random_noise();
        if ($urandom_range(0, 1))
            accumulate($urandom_range(0, 1), $urandom_range(0, 15),
                       legal_index($urandom_range(0, 31)), $urandom_range(0, 65535));
        else
            read_stat($urandom_range(0, 1), $urandom_range(0, 15), KW'($urandom_range(0, 3)),
                      $urandom_range(0, 31), $urandom_range(0, 511));
    endtask

    task automatic test_random(int quota);
        int stop_at;
        int n;
        stop_at = items_sent + quota;
        n = (int'(shadow_siu) > NS) ? NS : int'(shadow_siu);
        while (items_sent < stop_at) begin
            quiet_sender = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7) random_waveform(n);
            else random_noise();
        end
        quiet_sender = 0;
    endtask

    // The receiver stalls for a long stretch while reads keep coming, so the block backs up.
    task automatic test_backpressure();
        hold_request = hold_request + 1;
        quiet_sender = 1;
        repeat (20)
            read_stat($urandom_range(0, 1), $urandom_range(0, 15), KW'($urandom_range(0, 3)),
                      $urandom_range(0, 31), $urandom_range(0, NPAIR - 1));
        quiet_sender = 0;
    endtask

    // Walks through several register settings, the extremes among them.
    task automatic test_settings();
        write_register(wma_pkg::CFG_SAMPLES_IN_USE, 6'd32);
        write_register(wma_pkg::CFG_COV_ENABLE, 6'h3F);
        // Fill the whole buffer once so that later waveforms may start anywhere.
        for (int j = 0; j < NS; j++) accumulate(1, 9, j, $urandom_range(0, 65535));
        test_random(150);
        test_backpressure();
        write_register(wma_pkg::CFG_SAMPLES_IN_USE, 6'd5);
        test_random(100);
        write_register(wma_pkg::CFG_COV_ENABLE, 6'h3E);
        write_register(wma_pkg::CFG_SAMPLES_IN_USE, 6'd1);
        test_random(60);
        write_register(wma_pkg::CFG_SAMPLES_IN_USE, 6'd0);
        test_random(40);
        write_register(wma_pkg::CFG_SAMPLES_IN_USE, 6'd63);
        write_register(wma_pkg::CFG_COV_ENABLE, 6'h01);
        test_random(120);
        write_register(wma_pkg::CFG_SAMPLES_IN_USE, 6'd17);
        write_register(wma_pkg::CFG_COV_ENABLE, 6'h00);
        test_random(80);
        write_register(wma_pkg::CFG_COV_ENABLE, 6'h01);
        test_random(60);
    endtask

    // Receiver side: random ready, long holds on request, and the result check.
    always @(posedge i_clk) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_stats.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, rsp_ch.read_value);
                error_count++;
            end else begin
                if (rsp_ch.read_value !== owed_stats[0]) begin
                    $display("%0t: read_value mismatch, expected %h actual %h",
                             $time, owed_stats[0], rsp_ch.read_value);
                    error_count++;
                end
                void'(owed_stats.pop_front());
            end
        end
        if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 9) < 7) ||
                            ($urandom_range(0, 19) == 0 ? 1'b0 : quiet_sender);
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.action = '0;
        req_ch.gain = '0;
        req_ch.channel = '0;
        req_ch.sample_index = '0;
        req_ch.sample_value = '0;
        req_ch.stat_kind = '0;
        req_ch.pair_index = '0;
        rsp_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_settings();
        wait_drained();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
